// ===== design/omni3_pkg.sv =====
// Package: shared types, constants and tables for the omni3 drive mixer.
package omni3_pkg;

  localparam int ANGLE_BITS_DEF        = 16;
  localparam int DRIVE_FRAC_BITS_DEF   = 14;
  localparam int SINCOS_ITERATIONS_DEF = 16;

  localparam int ATAN_COUNT = 24;
  localparam int WF         = 30;
  localparam int CFG_W      = 31;
  localparam int CFG_IDX_W  = 3;

  // working width for Q30 values: sums of three terms of up to ~2^31
  localparam int VW = 34;

  localparam logic signed [VW-1:0] CORDIC_X0  = 34'sd652032874;
  localparam logic signed [VW-1:0] SQRT3_HALF = 34'sd929887697;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GYRO_DEADBAND  = 3'd0,
    REG_SPIN_START     = 3'd1,
    REG_SPIN_FAST      = 3'd2,
    REG_SLOW_SPIN      = 3'd3,
    REG_FAST_SPIN      = 3'd4,
    REG_COMMAND_WINDOW = 3'd5
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_MIX_A,
    ST_MIX_B,
    ST_MIX_C,
    ST_MAX,
    ST_DIV,
    ST_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // latch item, start
    logic cordic_step;
    logic mix_a;
    logic mix_b;
    logic mix_c;
    logic find_max;
    logic div_start;
    logic div_step;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_tick;
    logic fresh;
    logic cordic_done;
    logic div_done;
    logic div_last;
  } status_t;

  function automatic logic signed [VW-1:0] atan_turn(input logic [4:0] i);
    logic signed [VW-1:0] r;
    case (i)
      5'd0:  r = 34'sd536870912;
      5'd1:  r = 34'sd316933406;
      5'd2:  r = 34'sd167458907;
      5'd3:  r = 34'sd85004756;
      5'd4:  r = 34'sd42667331;
      5'd5:  r = 34'sd21354465;
      5'd6:  r = 34'sd10679838;
      5'd7:  r = 34'sd5340245;
      5'd8:  r = 34'sd2670163;
      5'd9:  r = 34'sd1335087;
      5'd10: r = 34'sd667544;
      5'd11: r = 34'sd333772;
      5'd12: r = 34'sd166886;
      5'd13: r = 34'sd83443;
      5'd14: r = 34'sd41722;
      5'd15: r = 34'sd20861;
      5'd16: r = 34'sd10430;
      5'd17: r = 34'sd5215;
      5'd18: r = 34'sd2608;
      5'd19: r = 34'sd1304;
      5'd20: r = 34'sd652;
      5'd21: r = 34'sd326;
      5'd22: r = 34'sd163;
      5'd23: r = 34'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/omni3_if.sv =====
// Interfaces: valid/ready channels for tick/gyro items and drive results.
interface omni3_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic signed [15:0] gyro_rate;
  logic [15:0] heading;
  logic [19:0] command_age;
  modport source (output valid, operation, gyro_rate, heading, command_age, input ready);
  modport sink   (input valid, operation, gyro_rate, heading, command_age, output ready);
endinterface

interface omni3_out_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] wheel_one_drive;
  logic signed [15:0] wheel_two_drive;
  logic signed [15:0] wheel_three_drive;
  logic        spin_active;
  logic        command_used;
  modport source (output valid, wheel_one_drive, wheel_two_drive, wheel_three_drive,
                  spin_active, command_used, input ready);
  modport sink   (input valid, wheel_one_drive, wheel_two_drive, wheel_three_drive,
                  spin_active, command_used, output ready);
endinterface

// ===== design/omni3_ctrl.sv =====
// Controller: sequences CORDIC, mix, max search and the three divisions.
module omni3_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_busy,
  input  omni3_pkg::status_t  status,
  output omni3_pkg::cmd_t     cmd
);

  omni3_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= omni3_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      omni3_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = omni3_pkg::ST_CORDIC;
        end
      end
      omni3_pkg::ST_CORDIC: begin
        if (!status.is_tick) begin
          state_next = omni3_pkg::ST_IDLE;
        end else if (!status.fresh) begin
          state_next = omni3_pkg::ST_OUT;
        end else if (status.cordic_done) begin
          state_next = omni3_pkg::ST_MIX_A;
        end else begin
          cmd.cordic_step = 1'b1;
        end
      end
      omni3_pkg::ST_MIX_A: begin
        cmd.mix_a  = 1'b1;
        state_next = omni3_pkg::ST_MIX_B;
      end
      omni3_pkg::ST_MIX_B: begin
        cmd.mix_b  = 1'b1;
        state_next = omni3_pkg::ST_MIX_C;
      end
      omni3_pkg::ST_MIX_C: begin
        cmd.mix_c  = 1'b1;
        state_next = omni3_pkg::ST_MAX;
      end
      omni3_pkg::ST_MAX: begin
        cmd.find_max  = 1'b1;
        cmd.div_start = 1'b1;
        state_next    = omni3_pkg::ST_DIV;
      end
      omni3_pkg::ST_DIV: begin
        if (status.div_done && status.div_last) begin
          state_next = omni3_pkg::ST_OUT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      omni3_pkg::ST_OUT: begin
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = omni3_pkg::ST_IDLE;
        end
      end
      default: state_next = omni3_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== design/omni3_dp.sv =====
// Datapath: config, accumulator, CORDIC, mixer, max and restoring divider.
module omni3_dp #(
  parameter int ANGLE_BITS        = omni3_pkg::ANGLE_BITS_DEF,
  parameter int DRIVE_FRAC_BITS   = omni3_pkg::DRIVE_FRAC_BITS_DEF,
  parameter int SINCOS_ITERATIONS = omni3_pkg::SINCOS_ITERATIONS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [omni3_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [omni3_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                  operation,
  input  logic signed [15:0]                    gyro_rate,
  input  logic [15:0]                           heading,
  input  logic [19:0]                           command_age,
  input  omni3_pkg::cmd_t                       cmd,
  output omni3_pkg::status_t                    status,
  output logic signed [15:0]                    drive [3],
  output logic                                  spin_flag,
  output logic                                  fresh_flag
);

  localparam int VW    = omni3_pkg::VW;
  localparam int IT    = (SINCOS_ITERATIONS < omni3_pkg::ATAN_COUNT) ?
                         SINCOS_ITERATIONS : omni3_pkg::ATAN_COUNT;
  localparam int IW    = $clog2(omni3_pkg::ATAN_COUNT + 1);
  localparam int SSH   = omni3_pkg::WF - DRIVE_FRAC_BITS;
  localparam int QW    = DRIVE_FRAC_BITS + 2;      // quotient magnitude bits
  localparam int CW    = $clog2(VW + QW + 3);
  localparam logic [15:0] ONE = 16'(1 << DRIVE_FRAC_BITS);
  localparam logic [31:0] ANGLE_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);

  // configuration registers
  logic [14:0] gyro_deadband, slow_spin_term, fast_spin_term;
  logic [30:0] spin_start_level, spin_fast_level;
  logic [19:0] command_window;

  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_deadband    <= 15'd10;
      spin_start_level <= 31'd300;
      spin_fast_level  <= 31'd450;
      slow_spin_term   <= 15'd4096;
      fast_spin_term   <= 15'd8192;
      command_window   <= 20'd20000;
    end else if (cfg_write) begin
      case (cfg_index)
        omni3_pkg::REG_GYRO_DEADBAND:  gyro_deadband    <= cfg_data[14:0];
        omni3_pkg::REG_SPIN_START:     spin_start_level <= cfg_data[30:0];
        omni3_pkg::REG_SPIN_FAST:      spin_fast_level  <= cfg_data[30:0];
        omni3_pkg::REG_SLOW_SPIN:      slow_spin_term   <= cfg_data[14:0];
        omni3_pkg::REG_FAST_SPIN:      fast_spin_term   <= cfg_data[14:0];
        omni3_pkg::REG_COMMAND_WINDOW: command_window   <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  // rotation accumulator, saturating
  logic signed [31:0] rotation_sum;
  logic signed [32:0] rot_t;
  logic [16:0]        rate_mag;
  logic               acc_en;

  assign rate_mag = gyro_rate[15] ? 17'(-{gyro_rate[15], gyro_rate})
                                  : 17'({1'b0, gyro_rate});
  assign acc_en   = cmd.load && !operation && (rate_mag > 17'(gyro_deadband));
  assign rot_t    = 33'(rotation_sum) + 33'(gyro_rate);

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation_sum <= '0;
    end else if (acc_en) begin
      if (rot_t > 33'sd2147483647)       rotation_sum <= 32'sh7FFFFFFF;
      else if (rot_t < -33'sd2147483648) rotation_sum <= 32'sh80000000;
      else                               rotation_sum <= rot_t[31:0];
    end
  end

  // item latch: spin term and freshness settle at load
  logic               is_tick, fresh;
  logic signed [16:0] spin;
  logic [32:0]        amag;
  logic [15:0]        spin_pick;

  assign amag      = rotation_sum[31] ? 33'(-{rotation_sum[31], rotation_sum})
                                      : 33'({1'b0, rotation_sum});
  assign spin_pick = (amag >= 33'(spin_fast_level)) ?
                     ((16'(fast_spin_term) > ONE) ? ONE : 16'(fast_spin_term)) :
                     ((16'(slow_spin_term) > ONE) ? ONE : 16'(slow_spin_term));

  // CORDIC
  logic signed [VW-1:0] cx, cy, cz;
  logic                 flip;
  logic [IW-1:0]        it;
  logic [31:0]          ang;

  assign ang = (32'(heading) & ANGLE_MASK) << (32 - ANGLE_BITS);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_tick    <= operation;
      fresh      <= command_age < command_window;
      spin_flag  <= amag >= 33'(spin_start_level);
      fresh_flag <= command_age < command_window;
      if (amag >= 33'(spin_start_level))
        spin <= rotation_sum[31] ? -17'(spin_pick) : 17'(spin_pick);
      else
        spin <= '0;
      flip <= ang[31] ^ ang[30];
      cx   <= omni3_pkg::CORDIC_X0;
      cy   <= '0;
      cz   <= VW'(signed'(ang ^ {ang[31] ^ ang[30], 31'd0}));
      it   <= '0;
    end else if (cmd.cordic_step) begin
      if (!cz[VW-1]) begin
        cx <= cx - (cy >>> it);
        cy <= cy + (cx >>> it);
        cz <= cz - omni3_pkg::atan_turn(5'(it));
      end else begin
        cx <= cx + (cy >>> it);
        cy <= cy - (cx >>> it);
        cz <= cz + omni3_pkg::atan_turn(5'(it));
      end
      it <= it + 1'b1;
    end
  end

  // mixing: a single multiply, shared by the second and third wheel sums
  logic signed [VW-1:0]     c, s, base;
  logic signed [2*VW-1:0]   prod, half;
  logic signed [VW-1:0]     v [3];
  logic signed [2*VW-1:0]   r1, r2;

  assign c    = flip ? -cx : cx;
  assign s    = flip ? -cy : cy;
  assign base = VW'(spin) <<< SSH;
  assign half = -((2*VW)'(c) <<< (omni3_pkg::WF - 1));
  assign r1   = half + prod + (2*VW)'(64'sd1 << (omni3_pkg::WF - 1));
  assign r2   = half - prod + (2*VW)'(64'sd1 << (omni3_pkg::WF - 1));

  // magnitudes and divider
  logic [VW-1:0]   vmag [3];
  logic [VW-1:0]   vmax;
  logic [1:0]      dsel;
  logic [CW-1:0]   dcnt;
  logic [VW+1:0]   rem;
  logic [VW+QW:0]  num;
  logic [QW-1:0]   quo;
  logic [VW+1:0]   rem_sh, rem_sub;
  logic signed [15:0] res [3];

  for (genvar k = 0; k < 3; k++) begin : g_mag
    assign vmag[k] = v[k][VW-1] ? -v[k] : v[k];
  end

  assign rem_sh  = {rem[VW:0], num[VW+QW]};
  assign rem_sub = rem_sh - {1'b0, vmax, 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.mix_a) begin
      v[0] <= base + c;
      prod <= (2*VW)'(omni3_pkg::SQRT3_HALF) * (2*VW)'(s);
    end
    if (cmd.mix_b) v[1] <= base + VW'(r1 >>> omni3_pkg::WF);
    if (cmd.mix_c) v[2] <= base + VW'(r2 >>> omni3_pkg::WF);
    if (cmd.find_max) begin
      vmax <= (vmag[0] >= vmag[1]) ? ((vmag[0] >= vmag[2]) ? vmag[0] : vmag[2])
                                   : ((vmag[1] >= vmag[2]) ? vmag[1] : vmag[2]);
    end
    // restoring division (2m<<F + vmax) / (2 vmax), one bit per cycle
    if (cmd.div_start) begin
      dsel <= '0;
      dcnt <= '0;
      rem  <= '0;
      quo  <= '0;
      num  <= '0;
    end else if (cmd.div_step) begin
      if (dcnt == '0 && quo == '0 && rem == '0 && num == '0) begin
        num  <= ((VW+QW+1)'(vmag[dsel]) << (DRIVE_FRAC_BITS + 1)) + (VW+QW+1)'(vmax);
        dcnt <= CW'(1);
      end else if (dcnt <= CW'(VW + QW + 1)) begin
        num  <= num << 1;
        if (!rem_sub[VW+1]) begin
          rem <= rem_sub;
          quo <= {quo[QW-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[QW-2:0], 1'b0};
        end
        dcnt <= dcnt + 1'b1;
      end else begin
        if (vmax == '0)       res[dsel] <= '0;
        else if (v[dsel][VW-1]) res[dsel] <= -16'(quo);
        else                  res[dsel] <= 16'(quo);
        dsel <= dsel + 1'b1;
        dcnt <= '0;
        rem  <= '0;
        quo  <= '0;
        num  <= '0;
      end
    end
  end

  // note: dcnt counts beyond QW bits; width sized to span numerator length
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (!fresh) drive[k] = 16'(spin);
      else        drive[k] = res[k];
    end
  end

  assign status.is_tick     = is_tick;
  assign status.fresh       = fresh;
  assign status.cordic_done = (it == IW'(IT));
  assign status.div_done    = (dsel == 2'd3);
  assign status.div_last    = (dsel == 2'd3);

endmodule

// ===== design/omni3_drive_mixer_with_spin_hold.sv =====
// Top level: three-wheel omni drive mixer with gyro spin hold.
//
//  channel  | dir | transfer carries
//  -------- | --- | ---------------------------------------------
//  in_ch    | in  | operation, gyro_rate, heading, command_age
//  out_ch   | out | three wheel drives, spin_active, command_used
//  cfg      | in  | write enable, register index, write data
//
// A gyro sample only feeds the rotation sum (above the deadband). A stale tick goes
// straight to the output load; a fresh tick runs the shared CORDIC stage, the mix,
// the max search and the three divisions in the bit-serial divider.
// Reset (rst, synchronous) restores register defaults and clears the sum.
// The output register holds a result while out is stalled; the next item is
// taken meanwhile and waits only at its own output load.
module omni3_drive_mixer_with_spin_hold #(
  parameter int ANGLE_BITS        = omni3_pkg::ANGLE_BITS_DEF,
  parameter int DRIVE_FRAC_BITS   = omni3_pkg::DRIVE_FRAC_BITS_DEF,
  parameter int SINCOS_ITERATIONS = omni3_pkg::SINCOS_ITERATIONS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [omni3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [omni3_pkg::CFG_W-1:0]     cfg_data,
  omni3_in_if.sink                        in_ch,
  omni3_out_if.source                     out_ch
);

  omni3_pkg::cmd_t    cmd;
  omni3_pkg::status_t status;
  logic signed [15:0] drive [3];
  logic               spin_flag, fresh_flag;

  omni3_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_busy (out_ch.valid && !out_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  omni3_dp #(
    .ANGLE_BITS        (ANGLE_BITS),
    .DRIVE_FRAC_BITS   (DRIVE_FRAC_BITS),
    .SINCOS_ITERATIONS (SINCOS_ITERATIONS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .operation   (in_ch.operation),
    .gyro_rate   (in_ch.gyro_rate),
    .heading     (in_ch.heading),
    .command_age (in_ch.command_age),
    .cmd         (cmd),
    .status      (status),
    .drive       (drive),
    .spin_flag   (spin_flag),
    .fresh_flag  (fresh_flag)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ch.wheel_one_drive   <= drive[0];
      out_ch.wheel_two_drive   <= drive[1];
      out_ch.wheel_three_drive <= drive[2];
      out_ch.spin_active       <= spin_flag;
      out_ch.command_used      <= fresh_flag;
    end
  end

endmodule
